// ----- hdl/four_d_rotor_vector_rotation_macros.svh -----
// ----------------------------------------------------------------------------
// four_d_rotor_vector_rotation_macros
// assertion macros for the 4d rotor rotation block, clocked on clk, reset rst
// ----------------------------------------------------------------------------
`ifndef FOUR_D_ROTOR_VECTOR_ROTATION_MACROS_SVH
`define FOUR_D_ROTOR_VECTOR_ROTATION_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked outside reset
`define FDR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked on every edge, reset included
`define FDR_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`else

`define FDR_ASSERT(label, prop, msg)
`define FDR_ASSERT_NR(label, prop, msg)

`endif

`endif

// ----- hdl/fdrvr_pkg.sv -----
// ----------------------------------------------------------------------------
// fdrvr_pkg
// widths, register indexes and sandwich product term tables for the 4d rotor
// rotation pipeline
// ----------------------------------------------------------------------------
package fdrvr_pkg;

  localparam int COORD_W = 32;
  localparam int ROTOR_W = 16;
  localparam int RF      = ROTOR_W - 2;

  localparam int N_REG    = 8;
  localparam int N_CRD    = 4;
  localparam int N_MID    = 8;
  localparam int N_OUT    = 4;
  localparam int S1_TERMS = 4;
  localparam int S2_TERMS = 8;
  localparam int S2_HALF  = S2_TERMS / 2;

  localparam int P1_W    = COORD_W + ROTOR_W;
  localparam int S1SUM_W = P1_W + 2;
  localparam int MID_W   = S1SUM_W - RF;
  localparam int P2_W    = MID_W + ROTOR_W;
  localparam int HALF_W  = P2_W + 2;
  localparam int S2SUM_W = P2_W + 3;
  localparam int RES_W   = S2SUM_W - RF;

  localparam int RND_HALF = 2 ** (RF - 1);

  typedef logic signed [ROTOR_W-1:0] rot_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [2:0]                idx_t;
  typedef logic [1:0]                crd_idx_t;

  localparam rot_t ROT_ONE = {2'b01, {RF{1'b0}}};

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [RES_W-1:0] RES_MAX =
    {{(RES_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = ~RES_MAX;

  // rotor register indexes
  localparam idx_t REG_SCALAR = 3'd0;
  localparam idx_t REG_XY     = 3'd1;
  localparam idx_t REG_XZ     = 3'd2;
  localparam idx_t REG_XW     = 3'd3;
  localparam idx_t REG_YZ     = 3'd4;
  localparam idx_t REG_YW     = 3'd5;
  localparam idx_t REG_ZW     = 3'd6;
  localparam idx_t REG_QUAD   = 3'd7;

  localparam crd_idx_t CRD_X = 2'd0;
  localparam crd_idx_t CRD_Y = 2'd1;
  localparam crd_idx_t CRD_Z = 2'd2;
  localparam crd_idx_t CRD_W = 2'd3;

  // intermediates: four vector terms, then four trivector terms
  localparam idx_t MID_SX  = 3'd0;
  localparam idx_t MID_SY  = 3'd1;
  localparam idx_t MID_SZ  = 3'd2;
  localparam idx_t MID_SW  = 3'd3;
  localparam idx_t MID_XYZ = 3'd4;
  localparam idx_t MID_XYW = 3'd5;
  localparam idx_t MID_XZW = 3'd6;
  localparam idx_t MID_YZW = 3'd7;

  // first product: rotor part and coordinate of each term, bit j set = subtract
  localparam idx_t S1_ROT [N_MID][S1_TERMS] = '{
    '{REG_SCALAR, REG_XW, REG_XY, REG_XZ},
    '{REG_SCALAR, REG_XY, REG_YW, REG_YZ},
    '{REG_SCALAR, REG_XZ, REG_YZ, REG_ZW},
    '{REG_SCALAR, REG_XW, REG_YW, REG_ZW},
    '{REG_XY,     REG_XZ, REG_YZ, REG_QUAD},
    '{REG_XW,     REG_XY, REG_YW, REG_QUAD},
    '{REG_XW,     REG_XZ, REG_ZW, REG_QUAD},
    '{REG_YW,     REG_YZ, REG_ZW, REG_QUAD}
  };
  localparam crd_idx_t S1_CRD [N_MID][S1_TERMS] = '{
    '{CRD_X, CRD_W, CRD_Y, CRD_Z},
    '{CRD_Y, CRD_X, CRD_W, CRD_Z},
    '{CRD_Z, CRD_X, CRD_Y, CRD_W},
    '{CRD_W, CRD_X, CRD_Y, CRD_Z},
    '{CRD_Z, CRD_Y, CRD_X, CRD_W},
    '{CRD_Y, CRD_W, CRD_X, CRD_Z},
    '{CRD_Z, CRD_W, CRD_X, CRD_Y},
    '{CRD_Z, CRD_W, CRD_Y, CRD_X}
  };
  localparam logic [S1_TERMS-1:0] S1_NEG [N_MID] = '{
    4'b0000, 4'b0010, 4'b0110, 4'b1110,
    4'b0010, 4'b1001, 4'b0001, 4'b1001
  };

  // second product: rotor part and intermediate of each term
  localparam idx_t S2_ROT [N_OUT][S2_TERMS] = '{
    '{REG_SCALAR, REG_XY, REG_XZ, REG_XW, REG_YW, REG_YZ, REG_ZW, REG_QUAD},
    '{REG_SCALAR, REG_XY, REG_YZ, REG_YW, REG_XW, REG_XZ, REG_ZW, REG_QUAD},
    '{REG_SCALAR, REG_XZ, REG_YZ, REG_ZW, REG_XW, REG_XY, REG_YW, REG_QUAD},
    '{REG_SCALAR, REG_XW, REG_YW, REG_ZW, REG_XY, REG_XZ, REG_YZ, REG_QUAD}
  };
  localparam idx_t S2_MID [N_OUT][S2_TERMS] = '{
    '{MID_SX, MID_SY, MID_SZ, MID_SW, MID_XYW, MID_XYZ, MID_XZW, MID_YZW},
    '{MID_SY, MID_SX, MID_SZ, MID_SW, MID_XYW, MID_XYZ, MID_YZW, MID_XZW},
    '{MID_SZ, MID_SX, MID_SY, MID_SW, MID_XZW, MID_XYZ, MID_YZW, MID_XYW},
    '{MID_SW, MID_SX, MID_SY, MID_SZ, MID_XYW, MID_XZW, MID_YZW, MID_XYZ}
  };
  localparam logic [S2_TERMS-1:0] S2_NEG [N_OUT] = '{
    8'b0000_0000, 8'b1011_0010, 8'b0101_0110, 8'b1000_1110
  };

endpackage

// ----- hdl/four_d_rotor_vector_rotation.sv -----
// ----------------------------------------------------------------------------
// four_d_rotor_vector_rotation
// throughput: one point per cycle while out_stall is low, through five register stages, two multiply
// reset: all stages empty, rotor set to identity (scalar part 1.0)
// ----------------------------------------------------------------------------
`include "four_d_rotor_vector_rotation_macros.svh"

module four_d_rotor_vector_rotation (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  fdrvr_pkg::idx_t          cfg_index,
  input  fdrvr_pkg::rot_t          cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  fdrvr_pkg::coord_t        in_x,
  input  fdrvr_pkg::coord_t        in_y,
  input  fdrvr_pkg::coord_t        in_z,
  input  fdrvr_pkg::coord_t        in_w,
  output logic                     out_valid,
  input  logic                     out_stall,
  output fdrvr_pkg::coord_t        out_x,
  output fdrvr_pkg::coord_t        out_y,
  output fdrvr_pkg::coord_t        out_z,
  output fdrvr_pkg::coord_t        out_w,
  output logic                     overflow
);

  localparam int NSTG = 5;

  fdrvr_pkg::rot_t   rot [fdrvr_pkg::N_REG];
  fdrvr_pkg::coord_t crd [fdrvr_pkg::N_CRD];

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  logic signed [fdrvr_pkg::P1_W-1:0]   p1 [fdrvr_pkg::N_REG][fdrvr_pkg::N_CRD];
  logic signed [fdrvr_pkg::MID_W-1:0]  mid [fdrvr_pkg::N_MID];
  logic signed [fdrvr_pkg::MID_W-1:0]  mid_next [fdrvr_pkg::N_MID];
  logic signed [fdrvr_pkg::P2_W-1:0]   p2 [fdrvr_pkg::N_OUT][fdrvr_pkg::S2_TERMS];
  logic signed [fdrvr_pkg::HALF_W-1:0] hsum [fdrvr_pkg::N_OUT][2];
  logic signed [fdrvr_pkg::HALF_W-1:0] hsum_next [fdrvr_pkg::N_OUT][2];
  fdrvr_pkg::coord_t res [fdrvr_pkg::N_OUT];
  fdrvr_pkg::coord_t res_next [fdrvr_pkg::N_OUT];
  logic              overflow_next;
  logic              sat_hit;

  assign cfg_ready = 1'b1;
  assign crd[fdrvr_pkg::CRD_X] = in_x;
  assign crd[fdrvr_pkg::CRD_Y] = in_y;
  assign crd[fdrvr_pkg::CRD_Z] = in_z;
  assign crd[fdrvr_pkg::CRD_W] = in_w;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NSTG-1];

  // first sums, rounded to intermediate width
  always_comb begin
    logic signed [fdrvr_pkg::S1SUM_W-1:0] acc;
    for (int i = 0; i < fdrvr_pkg::N_MID; i++) begin
      acc = '0;
      for (int j = 0; j < fdrvr_pkg::S1_TERMS; j++) begin
        if (fdrvr_pkg::S1_NEG[i][j]) begin
          acc = acc - fdrvr_pkg::S1SUM_W'(
            p1[fdrvr_pkg::S1_ROT[i][j]][fdrvr_pkg::S1_CRD[i][j]]);
        end else begin
          acc = acc + fdrvr_pkg::S1SUM_W'(
            p1[fdrvr_pkg::S1_ROT[i][j]][fdrvr_pkg::S1_CRD[i][j]]);
        end
      end
      acc = acc + fdrvr_pkg::S1SUM_W'(fdrvr_pkg::RND_HALF);
      mid_next[i] = fdrvr_pkg::MID_W'(acc >>> fdrvr_pkg::RF);
    end
  end

  // second sums, split in two halves
  always_comb begin
    logic signed [fdrvr_pkg::HALF_W-1:0] acc;
    for (int k = 0; k < fdrvr_pkg::N_OUT; k++) begin
      for (int h = 0; h < 2; h++) begin
        acc = '0;
        for (int j = 0; j < fdrvr_pkg::S2_HALF; j++) begin
          if (fdrvr_pkg::S2_NEG[k][h*fdrvr_pkg::S2_HALF+j]) begin
            acc = acc - fdrvr_pkg::HALF_W'(p2[k][h*fdrvr_pkg::S2_HALF+j]);
          end else begin
            acc = acc + fdrvr_pkg::HALF_W'(p2[k][h*fdrvr_pkg::S2_HALF+j]);
          end
        end
        hsum_next[k][h] = acc;
      end
    end
  end

  // final add, round and saturate
  always_comb begin
    logic signed [fdrvr_pkg::S2SUM_W-1:0] tot;
    logic signed [fdrvr_pkg::RES_W-1:0]   rnd;
    overflow_next = 1'b0;
    for (int k = 0; k < fdrvr_pkg::N_OUT; k++) begin
      tot = fdrvr_pkg::S2SUM_W'(hsum[k][0]) + fdrvr_pkg::S2SUM_W'(hsum[k][1])
          + fdrvr_pkg::S2SUM_W'(fdrvr_pkg::RND_HALF);
      rnd = fdrvr_pkg::RES_W'(tot >>> fdrvr_pkg::RF);
      if (rnd > fdrvr_pkg::RES_MAX) begin
        res_next[k]   = fdrvr_pkg::COORD_MAX;
        overflow_next = 1'b1;
      end else if (rnd < fdrvr_pkg::RES_MIN) begin
        res_next[k]   = fdrvr_pkg::COORD_MIN;
        overflow_next = 1'b1;
      end else begin
        res_next[k] = fdrvr_pkg::COORD_W'(rnd);
      end
    end
  end

  // control and rotor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      for (int r = 0; r < fdrvr_pkg::N_REG; r++) begin
        rot[r] <= (fdrvr_pkg::idx_t'(r) == fdrvr_pkg::REG_SCALAR) ? fdrvr_pkg::ROT_ONE : '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        rot[cfg_index] <= cfg_data;
      end
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int r = 0; r < fdrvr_pkg::N_REG; r++) begin
        for (int c = 0; c < fdrvr_pkg::N_CRD; c++) begin
          p1[r][c] <= rot[r] * crd[c];
        end
      end
    end
    if (en[1]) begin
      mid <= mid_next;
    end
    if (en[2]) begin
      for (int k = 0; k < fdrvr_pkg::N_OUT; k++) begin
        for (int j = 0; j < fdrvr_pkg::S2_TERMS; j++) begin
          p2[k][j] <= rot[fdrvr_pkg::S2_ROT[k][j]] * mid[fdrvr_pkg::S2_MID[k][j]];
        end
      end
    end
    if (en[3]) begin
      hsum <= hsum_next;
    end
    if (en[4]) begin
      res      <= res_next;
      overflow <= overflow_next;
    end
  end

  assign out_x = res[fdrvr_pkg::CRD_X];
  assign out_y = res[fdrvr_pkg::CRD_Y];
  assign out_z = res[fdrvr_pkg::CRD_Z];
  assign out_w = res[fdrvr_pkg::CRD_W];

  assign sat_hit = (out_x == fdrvr_pkg::COORD_MAX) || (out_x == fdrvr_pkg::COORD_MIN)
                || (out_y == fdrvr_pkg::COORD_MAX) || (out_y == fdrvr_pkg::COORD_MIN)
                || (out_z == fdrvr_pkg::COORD_MAX) || (out_z == fdrvr_pkg::COORD_MIN)
                || (out_w == fdrvr_pkg::COORD_MAX) || (out_w == fdrvr_pkg::COORD_MIN);

  `FDR_ASSERT_NR(a_reset_state, rst |=> !out_valid && !in_stall && (rot[fdrvr_pkg::REG_SCALAR] == fdrvr_pkg::ROT_ONE), "reset did not empty pipeline or load identity rotor")
  `FDR_ASSERT(a_input_flows, !out_stall |-> !in_stall, "input stalled while output drains")
  `FDR_ASSERT(a_flow_latency, in_valid && !in_stall && !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid, "transaction missing after pipeline latency")
  `FDR_ASSERT(a_overflow_bound, out_valid && overflow |-> sat_hit, "overflow set with no coordinate at a bound")

endmodule
